FILE: rtl/growing_window_time_histogram_macros.svh
// Assertion macros shared by the histogram block
`ifndef GROWING_WINDOW_TIME_HISTOGRAM_MACROS_SVH
`define GROWING_WINDOW_TIME_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define GWTH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gwth: same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define GWTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gwth: next-cycle check failed");

`endif

FILE: rtl/gwth_pkg.sv
// Package: widths, operation codes and controller interface types for the histogram
`timescale 1ns / 1ps
package gwth_pkg;

    localparam int TIME_W        = 32;
    localparam int AMT_W         = 32;
    localparam int COUNT_W       = 64;
    localparam int LEN_W         = 11;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic load;      // take the input item
        logic decide;    // work out window change for the held item
        logic clear_wr;  // write one zero of the cover sweep
        logic rd_en;     // read the addressed bin
        logic finish;    // write back and load the result register
    } ctl_cmd_t;

    typedef struct packed {
        logic need_clear;
        logic clear_last;
        logic out_free;
    } ctl_sts_t;

endpackage

FILE: rtl/gwth_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module gwth_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/gwth_ctrl.sv
// Controller state machine sequencing one item at a time
`timescale 1ns / 1ps
module gwth_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gwth_pkg::ctl_sts_t  sts,
    output gwth_pkg::ctl_cmd_t  cmd
);
    import gwth_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_MODIFY = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.need_clear ? ST_CLEAR : ST_READ;
            end
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                // hold here while the previous result is still waiting
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/gwth_datapath.sv
// Datapath: window registers, cover sweep, bin RAM read-modify-write, result register
`timescale 1ns / 1ps
module gwth_datapath #(
    parameter int DEPTH = gwth_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gwth_pkg::ctl_cmd_t            cmd,
    output gwth_pkg::ctl_sts_t            sts,
    input  logic                          s_operation,
    input  logic [gwth_pkg::TIME_W-1:0]   s_bin_time,
    input  logic [gwth_pkg::AMT_W-1:0]    s_add_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gwth_pkg::COUNT_W-1:0]  m_bin_count,
    output logic [gwth_pkg::TIME_W-1:0]   m_window_first,
    output logic [gwth_pkg::LEN_W-1:0]    m_window_length,
    output logic                          m_rejected
);
    import gwth_pkg::*;

    localparam int AW        = $clog2(DEPTH);
    localparam int LW        = $clog2(DEPTH + 1);
    localparam int RAM_DEPTH = 1 << AW;
    localparam logic [TIME_W:0] DEPTH_X = (TIME_W + 1)'(DEPTH);

    // held item
    logic              op_reg;
    logic [TIME_W-1:0] time_reg;
    logic [AMT_W-1:0]  amt_reg;

    // window
    logic [TIME_W-1:0] first_reg;
    logic [LW-1:0]     len_reg;

    // per-item decision
    logic          rej_reg;
    logic          hit_reg;
    logic          write_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [LW-1:0] clr_left_reg;

    // result register
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [TIME_W-1:0]  out_first_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_rej_reg;

    // decision logic, all on 33 bits so the window end never wraps
    logic [TIME_W:0] t_x, first_x, end_x, len_below, len_above, cnt_x, lo_x;
    logic            empty, is_add, below, above, too_wide, in_win, add_ok;
    logic [LW-1:0]   new_len;
    logic [LW+LEN_W-1:0] len_ext;

    always_comb begin
        t_x       = {1'b0, time_reg};
        first_x   = {1'b0, first_reg};
        end_x     = first_x + (TIME_W + 1)'(len_reg);
        empty     = (len_reg == '0);
        is_add    = (op_reg == OP_ADD);
        below     = !empty && (t_x < first_x);
        above     = !empty && (t_x >= end_x);
        len_below = end_x - t_x;
        len_above = t_x - first_x + 1'b1;
        too_wide  = (below && (len_below > DEPTH_X)) || (above && (len_above > DEPTH_X));
        in_win    = !empty && !below && !above;
        add_ok    = is_add && !too_wide;

        if (above) begin
            lo_x  = end_x;
            cnt_x = t_x - end_x + 1'b1;
        end else if (below) begin
            lo_x  = t_x;
            cnt_x = first_x - t_x;
        end else begin
            lo_x  = t_x;
            cnt_x = (TIME_W + 1)'(1);
        end

        priority if (empty) begin
            new_len = LW'(1);
        end else if (below) begin
            new_len = len_below[LW-1:0];
        end else if (above) begin
            new_len = len_above[LW-1:0];
        end else begin
            new_len = len_reg;
        end
    end

    assign sts.need_clear = add_ok && (empty || below || above);
    assign sts.clear_last = (clr_left_reg == LW'(1));
    assign sts.out_free   = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            time_reg <= s_bin_time;
            amt_reg  <= s_add_amount;
        end
        if (cmd.decide) begin
            rej_reg      <= is_add && too_wide;
            hit_reg      <= add_ok || in_win;
            write_reg    <= add_ok;
            clr_addr_reg <= lo_x[AW-1:0];
            clr_left_reg <= cnt_x[LW-1:0];
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            clr_left_reg <= clr_left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0;
            len_reg   <= '0;
        end else if (cmd.decide && add_ok) begin
            if (empty || below) begin
                first_reg <= time_reg;
            end
            len_reg <= new_len;
        end
    end

    // bins live at time modulo the RAM depth; a window of at most DEPTH bins never aliases
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] sum;

    assign sum = ram_rdata + COUNT_W'(amt_reg);

    always_comb begin
        if (cmd.clear_wr) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = cmd.finish && write_reg;
            ram_waddr = time_reg[AW-1:0];
            ram_wdata = sum;
        end
    end

    gwth_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (RAM_DEPTH)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (time_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign len_ext = {{LEN_W{1'b0}}, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_count_reg <= !hit_reg ? '0 : (write_reg ? sum : ram_rdata);
            out_first_reg <= first_reg;
            out_len_reg   <= len_ext[LEN_W-1:0];
            out_rej_reg   <= rej_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_bin_count     = out_count_reg;
    assign m_window_first  = out_first_reg;
    assign m_window_length = out_len_reg;
    assign m_rejected      = out_rej_reg;

endmodule

FILE: rtl/growing_window_time_histogram.sv
// Top level: time-binned 64-bit count histogram over a growing window
`timescale 1ns / 1ps
`include "growing_window_time_histogram_macros.svh"
// Items are handled one at a time. An item passes through accept, window decision, bin RAM
// read, and write-back with result load; its result is then offered from the output register.
// An add also runs a zeroing sweep before the read, one zero for each bin that it newly brings
// into the window, through the single RAM write port. Over the life of the block the sweep
// zeroes at most DEPTH bins in total.
// A result waits in an output register; the next item is taken meanwhile and is held
// in its last step until that register is free. There is no clearing pass after reset.
module growing_window_time_histogram #(
    parameter int DEPTH = gwth_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [gwth_pkg::TIME_W-1:0]   s_bin_time,
    input  logic [gwth_pkg::AMT_W-1:0]    s_add_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gwth_pkg::COUNT_W-1:0]  m_bin_count,
    output logic [gwth_pkg::TIME_W-1:0]   m_window_first,
    output logic [gwth_pkg::LEN_W-1:0]    m_window_length,
    output logic                          m_rejected
);
    import gwth_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    gwth_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gwth_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_operation     (s_operation),
        .s_bin_time      (s_bin_time),
        .s_add_amount    (s_add_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bin_count     (m_bin_count),
        .m_window_first  (m_window_first),
        .m_window_length (m_window_length),
        .m_rejected      (m_rejected)
    );

    `GWTH_ASSERT_IMP(a_finish_needs_room, aclk, aresetn, cmd.finish, sts.out_free)
    `GWTH_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    `GWTH_ASSERT_IMP(a_single_command, aclk, aresetn, 1'b1, $onehot0(cmd))

endmodule

FILE: tb/histogram_checker.sv
// Checker for the time-binned histogram: predicts each result and compares it with the block
`timescale 1ns / 1ps
module histogram_checker #(
    parameter int DEPTH = gwth_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_operation,
    input  logic [gwth_pkg::TIME_W-1:0]   s_bin_time,
    input  logic [gwth_pkg::AMT_W-1:0]    s_add_amount,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [gwth_pkg::COUNT_W-1:0]  m_bin_count,
    input  logic [gwth_pkg::TIME_W-1:0]   m_window_first,
    input  logic [gwth_pkg::LEN_W-1:0]    m_window_length,
    input  logic                          m_rejected,
    output int                            fail_count,
    output int                            pending,
    output int                            checked,
    output int                            reject_count,
    output int                            window_bins
);
    import gwth_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  first;
        logic [LEN_W-1:0]   len;
        logic               rej;
    } bin_result_t;

    bin_result_t        expected_bins[$];
    logic [COUNT_W-1:0] count_mem[DEPTH];
    logic [TIME_W-1:0]  win_first;
    int unsigned        win_len;

    // zero every bin newly brought into the window
    function automatic void clear_bins(longint unsigned lo_bin, longint unsigned hi_bin);
        for (longint unsigned b = lo_bin; b <= hi_bin; b++) begin
            count_mem[b % DEPTH] = '0;
        end
    endfunction

    function automatic bin_result_t apply_to_histogram(logic op, logic [TIME_W-1:0] t,
                                                       logic [AMT_W-1:0] amt);
        longint unsigned lo, hi, tb, span;
        logic fits;
        bin_result_t r;
        tb = t;
        lo = win_first;
        hi = lo + win_len;
        fits = 1'b1;
        if (op == OP_ADD) begin
            if (win_len == 0) begin
                clear_bins(tb, tb);
                win_first = t;
                win_len = 1;
            end else if (tb < lo) begin
                span = hi - tb;
                if (span > DEPTH) begin
                    fits = 1'b0;
                end else begin
                    clear_bins(tb, lo - 1);
                    win_first = t;
                    win_len = int'(span);
                end
            end else if (tb >= hi) begin
                // hi is 64 bits wide, so a window up to the top bin never wraps
                span = tb - lo + 1;
                if (span > DEPTH) begin
                    fits = 1'b0;
                end else begin
                    clear_bins(hi, tb);
                    win_len = int'(span);
                end
            end
            if (fits) begin
                count_mem[tb % DEPTH] += amt;
            end
        end
        lo = win_first;
        hi = lo + win_len;
        r.count = (win_len != 0 && tb >= lo && tb < hi) ? count_mem[tb % DEPTH] : '0;
        r.first = win_first;
        r.len   = LEN_W'(win_len);
        r.rej   = ~fits;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("mismatch in %s, result %0d: expected %h, got %h",
                         name, checked, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin
        bin_result_t want;
        if (!aresetn) begin
            expected_bins.delete();
            win_first    = '0;
            win_len      = 0;
            fail_count   = 0;
            checked      = 0;
            reject_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bins.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result with no item outstanding: count %h first %h len %0d",
                                 m_bin_count, m_window_first, m_window_length);
                    end
                end else begin
                    want = expected_bins.pop_front();
                    compare_field("bin_count", want.count, m_bin_count);
                    compare_field("window_first", 64'(want.first), 64'(m_window_first));
                    compare_field("window_length", 64'(want.len), 64'(m_window_length));
                    compare_field("rejected", 64'(want.rej), 64'(m_rejected));
                    if (m_rejected === 1'b1) begin
                        reject_count++;
                    end
                end
                checked++;
            end
            if (s_valid && s_ready) begin
                expected_bins.push_back(apply_to_histogram(s_operation, s_bin_time,
                                                           s_add_amount));
            end
        end
        pending     = expected_bins.size();
        window_bins = win_len;
    end

endmodule

FILE: tb/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the time-binned histogram
`timescale 1ns / 1ps
module testbench;
    import gwth_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam logic [TIME_W-1:0] TOP_BIN = '1;
    localparam logic [TIME_W-1:0] FULL_LO = TOP_BIN - TIME_W'(DEPTH - 1);
    localparam int RANDOM_ITEMS   = 1500;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 40;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic                s_operation  = OP_QUERY;
    logic [TIME_W-1:0]   s_bin_time   = '0;
    logic [AMT_W-1:0]    s_add_amount = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [COUNT_W-1:0]  m_bin_count;
    logic [TIME_W-1:0]   m_window_first;
    logic [LEN_W-1:0]    m_window_length;
    logic                m_rejected;

    int fail_count, pending, checked, reject_count, window_bins;

    bit                idle_on       = 1'b1;
    int                hold_requests = 0;
    int                n_adds        = 0;
    int                n_queries     = 0;
    logic [TIME_W-1:0] lo_mark       = TOP_BIN;

    growing_window_time_histogram #(.DEPTH(DEPTH)) u_top (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_operation, .s_bin_time, .s_add_amount,
        .m_valid, .m_ready, .m_bin_count, .m_window_first, .m_window_length, .m_rejected
    );

    histogram_checker #(.DEPTH(DEPTH)) u_chk (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_operation, .s_bin_time, .s_add_amount,
        .m_valid, .m_ready, .m_bin_count, .m_window_first, .m_window_length, .m_rejected,
        .fail_count, .pending, .checked, .reject_count, .window_bins
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random back-pressure plus long holds on request
    initial begin
        int hold_left;
        int holds_taken;
        hold_left = 0;
        holds_taken = 0;
        forever begin
            @(negedge aclk);
            if (holds_taken < hold_requests) begin
                holds_taken++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_on || ($urandom_range(99) >= 12);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_item(logic op, logic [TIME_W-1:0] t, logic [AMT_W-1:0] amt);
        while (idle_on && $urandom_range(99) < 12) begin
            s_valid      <= 1'b0;
            s_bin_time   <= $urandom;
            s_add_amount <= $urandom;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_bin_time   <= t;
        s_add_amount <= amt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (op == OP_ADD) begin
            n_adds++;
            // window top stays at TOP_BIN, so any add at or above FULL_LO is taken
            if (t >= FULL_LO && t < lo_mark) begin
                lo_mark = t;
            end
        end else begin
            n_queries++;
        end
    endtask

    task automatic wait_results_home();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic random_item();
        int pick;
        logic op;
        logic [TIME_W-1:0] t;
        logic [AMT_W-1:0] amt;
        pick = $urandom_range(99);
        op   = 1'($urandom_range(1));
        amt  = $urandom;
        if (pick < 45) begin
            t = lo_mark + $urandom_range(TOP_BIN - lo_mark);
        end else if (pick < 62) begin
            // just below the window: grows it, or is refused once it is full
            op = ($urandom_range(9) == 0) ? OP_QUERY : OP_ADD;
            t  = lo_mark - $urandom_range(12, 1);
        end else if (pick < 82) begin
            t = $urandom;
        end else begin
            case ($urandom_range(3))
                0:       t = '0;
                1:       t = TOP_BIN;
                2:       t = FULL_LO - 1;
                default: t = lo_mark - 1;
            endcase
            amt = $urandom_range(1) ? '1 : '0;
        end
        push_item(op, t, amt);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty window
        push_item(OP_QUERY, '0, '1);
        push_item(OP_QUERY, TOP_BIN, '0);
        // open near the top of the time range, then grow up to the last bin
        push_item(OP_ADD, 32'hFFFF_FF00, '1);
        push_item(OP_ADD, 32'hFFFF_FF00, '1);
        push_item(OP_QUERY, 32'hFFFF_FF00, 32'hDEAD_BEEF);
        push_item(OP_ADD, TOP_BIN, '0);
        push_item(OP_QUERY, TOP_BIN, '0);
        push_item(OP_ADD, TOP_BIN, 32'd1);
        push_item(OP_QUERY, 32'hFFFF_FF80, '0);
        // far below: too wide
        push_item(OP_ADD, '0, 32'd5);
        push_item(OP_QUERY, '0, '0);
        push_item(OP_ADD, 32'hFFFF_FEFF, 32'd7);
        push_item(OP_ADD, FULL_LO - 1, 32'h1234_5678);
        push_item(OP_QUERY, 32'hFFFF_FEFE, '0);
        push_item(OP_ADD, 32'hFFFF_FEF0, 32'hAAAA_AAAA);
        push_item(OP_ADD, 32'h5555_5555, 32'h5555_5555);
        push_item(OP_QUERY, 32'hFFFF_FEF0, 32'h5555_5555);
        push_item(OP_ADD, 32'hFFFF_FEF0, 32'h5555_5555);
        push_item(OP_QUERY, 32'hFFFF_FEF5, '1);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = !(i >= 500 && i < 800);
            if (i == 300) begin
                hold_requests++;
            end
            if (i == 900) begin
                wait_results_home();
            end
            random_item();
        end

        wait_results_home();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Sent %0d items (%0d adds, %0d queries) incl. a long result stall and a drain.",
                 n_adds + n_queries, n_adds, n_queries);
        $display("Checked %0d results, %0d adds refused as too wide, window ended at %0d bins.",
                 checked, reject_count, window_bins);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/gwth_pkg.sv
rtl/gwth_ram.sv
rtl/gwth_ctrl.sv
rtl/gwth_datapath.sv
rtl/growing_window_time_histogram.sv
tb/histogram_checker.sv
tb/testbench.sv
